>>> rtl/ccs_pkg.sv
// Shared constants and register codes for the chunk crossfade stitcher.
`default_nettype none

package ccs_pkg;

   // Field widths fixed by the item formats.
   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int WEIGHT_W = FRAC_W + 1;
   localparam int ACC_W    = 36;

   // Configuration register widths.
   localparam int CHUNK_LEN_W   = 20;
   localparam int OVERLAP_LEN_W = 17;
   localparam int STREAM_LEN_W  = 32;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 4;

   // Default sizes of the tail store and of a chunk.
   localparam int MAX_OVERLAP_DEF = 65536;
   localparam int MAX_CHUNK_DEF   = 524288;

   // Register reset values.
   localparam logic [CHUNK_LEN_W-1:0]   CHUNK_LEN_RST   = 20'h80000;
   localparam logic [OVERLAP_LEN_W-1:0] OVERLAP_LEN_RST = 17'h10000;
   localparam logic [STREAM_LEN_W-1:0]  STREAM_LEN_RST  = 32'hFFFF_FFFF;

   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   typedef enum logic [1:0] {
      CSR_CHUNK_LEN   = 2'd0,
      CSR_OVERLAP_LEN = 2'd1,
      CSR_STREAM_LEN  = 2'd2
   } csr_reg_type;

endpackage

`default_nettype wire

>>> rtl/chunk_crossfade_stitcher_unit.sv
// Overlap-add stitcher with a linear crossfade, bit-serial divider and multiplier.
// Each item passes in order through the accepting state, a setup step, the divider for both
// weights side by side, a weight select, the shift-add blend and a finishing step.
// The result is registered in the finishing step, and a new item is accepted only after it;
// the finishing step of an emitting item waits while an earlier result still sits unaccepted.
// Synchronous reset restores the registers and the chunk position; the tail store is not reset.
`default_nettype none

module chunk_crossfade_stitcher_unit #(
   parameter int MAX_OVERLAP = ccs_pkg::MAX_OVERLAP_DEF,
   parameter int MAX_CHUNK   = ccs_pkg::MAX_CHUNK_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // Input channel.
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [ccs_pkg::SAMPLE_W-1:0]        req_tdata,  // sample_in
   input  wire  [1:0]                          req_tuser,  // first_chunk, last_chunk
   // Result channel.
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [ccs_pkg::SAMPLE_W+ccs_pkg::INDEX_W-1:0] rsp_tdata, // sample_out, out_index
   // Configuration port.
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [ccs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [ccs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ccs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import ccs_pkg::*;

   localparam int CW    = $clog2(MAX_CHUNK + 1);
   localparam int OW    = $clog2(MAX_OVERLAP + 1);
   localparam int RW    = OW + 1;
   localparam int AW    = (MAX_OVERLAP > 1) ? $clog2(MAX_OVERLAP) : 1;
   localparam int CNT_W = $clog2(WEIGHT_W);
   localparam int YW    = ACC_W - FRAC_W;

   localparam logic [CNT_W-1:0]    CNT_LAST  = CNT_W'(WEIGHT_W - 1);
   localparam logic [WEIGHT_W-1:0] W_ONE     = WEIGHT_W'(1) << FRAC_W;
   localparam logic [ACC_W-1:0]    ACC_ROUND = ACC_W'(1) << (FRAC_W - 1);
   localparam logic signed [YW-1:0] Y_HI     = YW'(SAMPLE_MAX);
   localparam logic signed [YW-1:0] Y_LO     = YW'(SAMPLE_MIN);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_WEIGHT,
      ST_MUL,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic [CHUNK_LEN_W-1:0]   chunk_len_ff, chunk_len_in;
   logic [OVERLAP_LEN_W-1:0] overlap_len_ff, overlap_len_in;
   logic [STREAM_LEN_W-1:0]  stream_len_ff, stream_len_in;

   // Control state.
   state_type        state_ff, state_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [INDEX_W-1:0] cs_ff, cs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Per-item payload.
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic             first_ff, first_in;
   logic             last_ff, last_in;
   logic [CW-1:0]    k_ff, k_in;
   logic             head_ff, head_in;
   logic             tail_ff, tail_in;
   logic [INDEX_W-1:0] pos_ff, pos_in;
   logic [RW-1:0]    rfi_ff, rfi_in;
   logic [RW-1:0]    rfo_ff, rfo_in;
   logic [WEIGHT_W-1:0] qfi_ff, qfi_in;
   logic [WEIGHT_W-1:0] qfo_ff, qfo_in;
   logic [WEIGHT_W-1:0] wsh_ff, wsh_in;
   logic signed [ACC_W-1:0] msh_ff, msh_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   // Tail store.
   logic [SAMPLE_W-1:0] tail_mem [MAX_OVERLAP];
   logic signed [SAMPLE_W-1:0] prev_ff;

   // Effective lengths.
   logic [CW-1:0]    cl;
   logic [OW-1:0]    ov;
   logic [CW-1:0]    stride;
   logic [31:0]      ov32;

   // Helpers.
   logic [CW-1:0]    k_pre;
   logic [INDEX_W-1:0] cs_pre;
   logic [CW-1:0]    dist_pre;
   logic [RW-1:0]    rfi_sh, rfo_sh;
   logic             bit_fi, bit_fo;
   logic [WEIGHT_W-1:0] w_sel;
   logic signed [SAMPLE_W-1:0] prev_use;
   logic signed [SAMPLE_W:0] diff;
   logic signed [YW-1:0] y_wide;
   logic signed [SAMPLE_W-1:0] y_sat;
   logic             emit;
   logic             fin_go;
   logic [CW-1:0]    k_next;
   logic             csr_wr;

   always_comb begin
      if (32'(chunk_len_ff) > 32'(MAX_CHUNK)) begin
         cl = CW'(MAX_CHUNK);
      end else if (chunk_len_ff == '0) begin
         cl = CW'(1);
      end else begin
         cl = CW'(chunk_len_ff);
      end
      ov32 = 32'(overlap_len_ff);
      if (ov32 > 32'(MAX_OVERLAP)) begin
         ov32 = 32'(MAX_OVERLAP);
      end
      if (ov32 > 32'(cl) - 32'd1) begin
         ov32 = 32'(cl) - 32'd1;
      end
      ov     = OW'(ov32);
      stride = cl - CW'(ov);
   end

   // A length change between items can leave the index past the chunk end;
   // a new chunk then starts before the item is placed.
   always_comb begin
      if (idx_ff >= cl) begin
         k_pre  = '0;
         cs_pre = cs_ff + INDEX_W'(stride);
      end else begin
         k_pre  = idx_ff;
         cs_pre = cs_ff;
      end
      dist_pre = cl - k_pre;
   end

   // One restoring step per cycle; the first step compares without a shift.
   always_comb begin
      if (cnt_ff == '0) begin
         rfi_sh = rfi_ff;
         rfo_sh = rfo_ff;
      end else begin
         rfi_sh = {rfi_ff[RW-2:0], 1'b0};
         rfo_sh = {rfo_ff[RW-2:0], 1'b0};
      end
      bit_fi = (rfi_sh >= RW'(ov));
      bit_fo = (rfo_sh >= RW'(ov));
   end

   // Outside the head region the held tail does not take part in the blend.
   always_comb begin
      w_sel = W_ONE;
      if (head_ff) begin
         w_sel = qfi_ff;
      end
      if (tail_ff && (qfo_ff < w_sel)) begin
         w_sel = qfo_ff;
      end
      prev_use = head_ff ? prev_ff : '0;
      diff = (SAMPLE_W + 1)'(x_ff) - (SAMPLE_W + 1)'(prev_use);
   end

   always_comb begin
      y_wide = acc_ff[ACC_W-1:FRAC_W];
      if (y_wide > Y_HI) begin
         y_sat = SAMPLE_W'(Y_HI);
      end else if (y_wide < Y_LO) begin
         y_sat = SAMPLE_W'(Y_LO);
      end else begin
         y_sat = y_wide[SAMPLE_W-1:0];
      end
      emit   = !tail_ff && (pos_ff < stream_len_ff);
      fin_go = !emit || !rsp_valid_ff || rsp_tready;
      k_next = k_ff + CW'(1);
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      chunk_len_in   = chunk_len_ff;
      overlap_len_in = overlap_len_ff;
      stream_len_in  = stream_len_ff;
      if (csr_wr) begin
         unique case (csr_reg_type'(csr_paddr[3:2]))
            CSR_CHUNK_LEN:   chunk_len_in   = csr_pwdata[CHUNK_LEN_W-1:0];
            CSR_OVERLAP_LEN: overlap_len_in = csr_pwdata[OVERLAP_LEN_W-1:0];
            CSR_STREAM_LEN:  stream_len_in  = csr_pwdata[STREAM_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg_type'(csr_paddr[3:2]))
         CSR_CHUNK_LEN:   csr_prdata = CSR_DATA_W'(chunk_len_ff);
         CSR_OVERLAP_LEN: csr_prdata = CSR_DATA_W'(overlap_len_ff);
         CSR_STREAM_LEN:  csr_prdata = CSR_DATA_W'(stream_len_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cs_in         = cs_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      x_in          = x_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      k_in          = k_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      pos_in        = pos_ff;
      rfi_in        = rfi_ff;
      rfo_in        = rfo_ff;
      qfi_in        = qfi_ff;
      qfo_in        = qfo_ff;
      wsh_in        = wsh_ff;
      msh_in        = msh_ff;
      acc_in        = acc_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_index_in  = rsp_index_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_tdata;
               first_in = req_tuser[0];
               last_in  = req_tuser[1];
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            k_in     = k_pre;
            idx_in   = k_pre;
            cs_in    = cs_pre;
            pos_in   = cs_pre + INDEX_W'(k_pre);
            head_in  = !first_ff && (32'(k_pre) < 32'(ov));
            tail_in  = !last_ff && (32'(dist_pre) <= 32'(ov));
            rfi_in   = RW'(k_pre);
            rfo_in   = RW'(dist_pre);
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rfi_in = bit_fi ? (rfi_sh - RW'(ov)) : rfi_sh;
            rfo_in = bit_fo ? (rfo_sh - RW'(ov)) : rfo_sh;
            qfi_in = {qfi_ff[WEIGHT_W-2:0], bit_fi};
            qfo_in = {qfo_ff[WEIGHT_W-2:0], bit_fo};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            // prev*(1-w) + x*w is formed as prev*1.0 + (x-prev)*w.
            wsh_in   = w_sel;
            msh_in   = ACC_W'(diff);
            acc_in   = (ACC_W'(prev_use) <<< FRAC_W) + ACC_ROUND;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (wsh_ff[0]) begin
               acc_in = acc_ff + msh_ff;
            end
            msh_in = msh_ff <<< 1;
            wsh_in = wsh_ff >> 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fin_go) begin
               if (emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_sample_in = y_sat;
                  rsp_index_in  = pos_ff;
               end
               if (k_next >= cl) begin
                  idx_in = '0;
                  cs_in  = cs_ff + INDEX_W'(stride);
               end else begin
                  idx_in = k_next;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         cs_ff          <= '0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         chunk_len_ff   <= CHUNK_LEN_RST;
         overlap_len_ff <= OVERLAP_LEN_RST;
         stream_len_ff  <= STREAM_LEN_RST;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         cs_ff          <= cs_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         chunk_len_ff   <= chunk_len_in;
         overlap_len_ff <= overlap_len_in;
         stream_len_ff  <= stream_len_in;
      end
      x_ff          <= x_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      k_ff          <= k_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      pos_ff        <= pos_in;
      rfi_ff        <= rfi_in;
      rfo_ff        <= rfo_in;
      qfi_ff        <= qfi_in;
      qfo_ff        <= qfo_in;
      wsh_ff        <= wsh_in;
      msh_ff        <= msh_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_index_ff  <= rsp_index_in;
   end

   // The tail of a chunk lands at its offset from the stride, which is always
   // below the overlap and so inside the store.
   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         prev_ff <= tail_mem[AW'(k_pre)];
      end
      if ((state_ff == ST_FINISH) && tail_ff) begin
         tail_mem[AW'(k_ff - stride)] <= y_sat;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_index_ff, rsp_sample_ff};
   assign csr_pready = 1'b1;

endmodule

`default_nettype wire

>>> bench/chunk_crossfade_stitcher_unit_tb.sv
// Self-checking testbench for the chunk crossfade stitcher with its own blend predictor.
module chunk_crossfade_stitcher_unit_tb;
   import ccs_pkg::*;

   localparam int CLOCK_LIMIT   = 2_000_000;
   localparam int RANDOM_ITEMS  = 1850;
   localparam int SETTLE_CYCLES = 60;
   localparam int MAX_OVERLAP   = MAX_OVERLAP_DEF;
   localparam int MAX_CHUNK     = MAX_CHUNK_DEF;
   localparam int DIRECTED_ROWS = 29;

   typedef struct packed {
      logic [SAMPLE_W-1:0] level;
      logic [INDEX_W-1:0]  position;
   } out_sample_type;

   typedef enum logic { ROW_ITEM, ROW_CSR } row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      csr_reg_type         sel;
      logic [31:0]         value;
      logic [SAMPLE_W-1:0] sample;
      logic                first;
      logic                last;
      logic                typed;
      logic [SAMPLE_W-1:0] exp_level;
      logic [INDEX_W-1:0]  exp_position;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [SAMPLE_W-1:0]             req_tdata = '0;  // sample_in
   logic [1:0]                      req_tuser = '0;  // first_chunk, last_chunk
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [SAMPLE_W+INDEX_W-1:0]     rsp_tdata;       // sample_out, out_index
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]           csr_paddr = '0;
   logic [CSR_DATA_W-1:0]           csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]           csr_prdata;
   logic                            csr_pready;

   // Predictor copy of the registers and the stitching state.
   logic [CHUNK_LEN_W-1:0]   cfg_chunk   = CHUNK_LEN_RST;
   logic [OVERLAP_LEN_W-1:0] cfg_overlap = OVERLAP_LEN_RST;
   logic [STREAM_LEN_W-1:0]  cfg_stream  = STREAM_LEN_RST;
   int unsigned              pos_in_chunk = 0;
   logic [31:0]              chunk_base = '0;
   logic [SAMPLE_W-1:0]      tail_mem [MAX_OVERLAP];
   bit                       tail_written [MAX_OVERLAP];

   out_sample_type pending_outputs [$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   int          rx_gap = 0;
   bit          steady = 1'b0;

   // Directed rows: extremes after reset, mid-chunk length change, zero overlap,
   // dropped positions, clamped registers and an overlap above half the chunk.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h7FFF, 1'b1, 1'b1, 1'b1, 16'h7FFF, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h8000, 1'b1, 1'b0, 1'b1, 16'h8000, 32'd1},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h0001, 1'b1, 1'b0, 1'b1, 16'h0001, 32'd2},
      '{ROW_CSR,  CSR_CHUNK_LEN,   32'd2,        16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h1234, 1'b1, 1'b0, 1'b1, 16'h1234, 32'd1},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h4000, 1'b1, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'hFFFF, 1'b0, 1'b1, 1'b1, 16'h4000, 32'd2},
      '{ROW_CSR,  CSR_OVERLAP_LEN, 32'd0,        16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h5A5A, 1'b0, 1'b0, 1'b1, 16'h5A5A, 32'd3},
      '{ROW_CSR,  CSR_CHUNK_LEN,   32'd0,        16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h7FFF, 1'b0, 1'b0, 1'b1, 16'h7FFF, 32'd4},
      '{ROW_CSR,  CSR_STREAM_LEN,  32'd0,        16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h0F0F, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_CSR,  CSR_STREAM_LEN,  32'd7,        16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'hF0F0, 1'b1, 1'b1, 1'b1, 16'hF0F0, 32'd6},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h00FF, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd0},
      '{ROW_CSR,  CSR_STREAM_LEN,  32'hFFFFFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_CSR,  CSR_CHUNK_LEN,   32'hFFFFF,    16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_CSR,  CSR_OVERLAP_LEN, 32'h1FFFF,    16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h8001, 1'b1, 1'b0, 1'b1, 16'h8001, 32'd8},
      '{ROW_CSR,  CSR_CHUNK_LEN,   32'd4,        16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_CSR,  CSR_OVERLAP_LEN, 32'd3,        16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h2000, 1'b1, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h7FFF, 1'b1, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h8000, 1'b1, 1'b0, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'hFFFF, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h7FFF, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd0},
      '{ROW_ITEM, CSR_CHUNK_LEN,   32'h0,        16'h8000, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd0}
   };

   chunk_crossfade_stitcher_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CLOCK_LIMIT) begin
         $display("chunk_crossfade_stitcher_unit verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int unsigned eff_chunk();
      int unsigned c;
      c = cfg_chunk;
      if (c > MAX_CHUNK) c = MAX_CHUNK;
      if (c < 1) c = 1;
      return c;
   endfunction

   function automatic int unsigned eff_overlap(input int unsigned cl);
      int unsigned o;
      o = cfg_overlap;
      if (o > MAX_OVERLAP) o = MAX_OVERLAP;
      if (o > cl - 1) o = cl - 1;
      return o;
   endfunction

   // Advances the predicted stitching state by one item; returns 1 when it emits.
   function automatic bit stitch_sample(input logic [SAMPLE_W-1:0] x_bits, input bit first,
                                        input bit last, output out_sample_type res);
      int unsigned cl, ov, stride, k, span, w, fade_out, slot;
      int          prev, x;
      longint      acc, y;
      bit          head, tail;
      cl = eff_chunk();
      ov = eff_overlap(cl);
      stride = cl - ov;
      if (pos_in_chunk >= cl) begin
         pos_in_chunk = 0;
         chunk_base += stride;
      end
      k = pos_in_chunk;
      x = int'($signed(x_bits));
      w = 65536;
      head = !first && k < ov;
      if (head) w = 32'((longint'(k) << 16) / ov);
      span = cl - k;
      tail = !last && span <= ov;
      if (tail) begin
         fade_out = 32'((longint'(span) << 16) / ov);
         if (fade_out < w) w = fade_out;
      end
      prev = head ? int'($signed(tail_mem[k])) : 0;
      acc = longint'(prev) * longint'(65536 - w) + longint'(x) * longint'(w) + 32768;
      y = acc >>> 16;
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      res.level = y[SAMPLE_W-1:0];
      res.position = chunk_base + k;
      pos_in_chunk = k + 1;
      if (pos_in_chunk >= cl) begin
         pos_in_chunk = 0;
         chunk_base += stride;
      end
      if (tail) begin
         slot = k - stride;
         if (slot < MAX_OVERLAP) begin
            tail_mem[slot] = y[SAMPLE_W-1:0];
            tail_written[slot] = 1'b1;
         end
         return 1'b0;
      end
      return res.position < cfg_stream;
   endfunction

   function automatic int idle_cycles();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(16, 120);
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'h0001;
         endcase
      end
      return 16'($urandom());
   endfunction

   task automatic write_register(input csr_reg_type sel, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(sel));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (sel)
         CSR_CHUNK_LEN: begin
            cfg_chunk = value[CHUNK_LEN_W-1:0];
            mask = 32'h000F_FFFF;
         end
         CSR_OVERLAP_LEN: begin
            cfg_overlap = value[OVERLAP_LEN_W-1:0];
            mask = 32'h0001_FFFF;
         end
         default: begin
            cfg_stream = value;
            mask = 32'hFFFF_FFFF;
         end
      endcase
      // Read the register straight back with psel held high.
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if ((readback & mask) !== (value & mask))
         report_mismatch($sformatf("register %s reads %h, wrote %h",
                                   sel.name(), readback, value));
      @(posedge clock);
   endtask

   task automatic push_item(input logic [SAMPLE_W-1:0] x, input bit first_in, input bit last,
                            input bit typed, input out_sample_type typed_out);
      int unsigned cl, ov, k;
      int          gap;
      bit          first;
      bit          emits;
      out_sample_type predicted;
      first = first_in;
      cl = eff_chunk();
      ov = eff_overlap(cl);
      k = (pos_in_chunk >= cl) ? 0 : pos_in_chunk;
      // A head sample must never blend with a tail entry that no chunk has written.
      if (!first && k < ov && !tail_written[k]) first = 1'b1;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= x;
      req_tuser <= {last, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      emits = stitch_sample(x, first, last, predicted);
      if (typed) pending_outputs.push_back(typed_out);
      else if (emits) pending_outputs.push_back(predicted);
      items_sent++;
   endtask

   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase();
      int unsigned cl_raw, ov_raw, stream_raw, cl, k;
      int          pick, chunks, budget, n;
      bit          first, last;
      out_sample_type none;
      none = '0;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         case ($urandom_range(0, 4))
            0: cl_raw = 0;
            1: cl_raw = 1;
            2: cl_raw = 20'hFFFFF;
            3: cl_raw = MAX_CHUNK;
            default: cl_raw = MAX_CHUNK + 1;
         endcase
         case ($urandom_range(0, 4))
            0: ov_raw = 0;
            1: ov_raw = 17'h1FFFF;
            2: ov_raw = MAX_OVERLAP;
            3: ov_raw = MAX_OVERLAP + 1;
            default: ov_raw = 1;
         endcase
      end else begin
         cl_raw = $urandom_range(2, pick < 80 ? 24 : 96);
         pick = $urandom_range(0, 99);
         if (pick < 15) ov_raw = 0;
         else if (pick < 75) ov_raw = $urandom_range(1, cl_raw / 2);
         else ov_raw = $urandom_range(cl_raw / 2 + 1, cl_raw + 3);
      end
      pick = $urandom_range(0, 99);
      if (pick < 78) stream_raw = 32'hFFFF_FFFF;
      else if (pick < 90) stream_raw = chunk_base + $urandom_range(0, 60);
      else if (pick < 95) stream_raw = 0;
      else stream_raw = $urandom();
      steady = ($urandom_range(0, 4) == 0);
      write_register(CSR_CHUNK_LEN, cl_raw);
      write_register(CSR_OVERLAP_LEN, ov_raw);
      write_register(CSR_STREAM_LEN, stream_raw);
      cl = eff_chunk();
      budget = $urandom_range(20, 60);
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 30))
            push_item(random_sample(), $urandom_range(0, 1), $urandom_range(0, 1), 1'b0, none);
      end else begin
         // Well-formed run of chunks, each fed to its end unless the budget runs out.
         chunks = $urandom_range(1, 5);
         for (int c = 0; c < chunks && budget > 0; c++) begin
            first = (c == 0) && ($urandom_range(0, 1) == 1);
            last = (c == chunks - 1) && ($urandom_range(0, 1) == 1);
            k = (pos_in_chunk >= cl) ? 0 : pos_in_chunk;
            n = (cl - k > budget) ? budget : int'(cl - k);
            repeat (n) push_item(random_sample(), first, last, 1'b0, none);
            budget -= n;
         end
      end
   endtask

   task automatic check_output(input logic [SAMPLE_W+INDEX_W-1:0] data);
      out_sample_type want;
      if (pending_outputs.size() == 0) begin
         report_mismatch($sformatf("unexpected item: sample %h index %0d",
                                   data[SAMPLE_W-1:0], data[SAMPLE_W +: INDEX_W]));
         return;
      end
      want = pending_outputs.pop_front();
      if (data[SAMPLE_W-1:0] !== want.level)
         report_mismatch($sformatf("sample %h, expected %h at index %0d",
                                   data[SAMPLE_W-1:0], want.level, want.position));
      if (data[SAMPLE_W +: INDEX_W] !== want.position)
         report_mismatch($sformatf("index %0d, expected %0d",
                                   data[SAMPLE_W +: INDEX_W], want.position));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_output(rsp_tdata);
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rx_gap = idle_cycles();
         stall_left = (rx_gap > 0) ? rx_gap - 1 : 0;
         rsp_tready <= (rx_gap == 0);
      end
   end

   initial begin : stimulus
      int start_count;
      out_sample_type typed_out;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_outputs();
            write_register(directed_rows[i].sel, directed_rows[i].value);
         end else begin
            typed_out.level = directed_rows[i].exp_level;
            typed_out.position = directed_rows[i].exp_position;
            push_item(directed_rows[i].sample, directed_rows[i].first, directed_rows[i].last,
                      directed_rows[i].typed, typed_out);
         end
      end
      start_count = items_sent;
      while (items_sent < start_count + RANDOM_ITEMS) begin
         drain_outputs();
         random_phase();
      end
      drain_outputs();
      if (mismatches == 0 && pending_outputs.size() == 0) begin
         $display("chunk_crossfade_stitcher_unit verification clean");
      end else begin
         $display("chunk_crossfade_stitcher_unit verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/ccs_pkg.sv
rtl/chunk_crossfade_stitcher_unit.sv
bench/chunk_crossfade_stitcher_unit_tb.sv
